// File: rtl/core/alt_pkg.sv
// Shared types and constants for the address lease table.
package alt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int MAC_W   = 48;
    localparam int ADDR_W  = 32;
    localparam int LEASE_W = 31;
    localparam int SIZE_W  = 6;

    // Aging step of one tick, in seconds
    localparam int AGE_STEP = 10;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;

    localparam logic [2:0] ST_OFFER     = 3'd0;
    localparam logic [2:0] ST_ACK       = 3'd1;
    localparam logic [2:0] ST_IGNORED   = 3'd2;
    localparam logic [2:0] ST_NO_SERVER = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_TICK      = 3'd5;

    localparam logic [1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [1:0] CFG_POOL_SIZE     = 2'd1;
    localparam logic [1:0] CFG_LEASE_SECONDS = 2'd2;
    localparam logic [1:0] CFG_DERIVE_SUBNET = 2'd3;

    localparam logic [ADDR_W-1:0]  RST_POOL_BASE     = 32'hC0A8_0164;
    localparam logic [SIZE_W-1:0]  RST_POOL_SIZE     = 6'd50;
    localparam logic [LEASE_W-1:0] RST_LEASE_SECONDS = 31'd3600;
    localparam logic               RST_DERIVE_SUBNET = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/alt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/address_lease_table_core.sv
// Lease table of an address server: request lookup/allocation and lease aging.
// The slot scan covers N = min(pool_size, TABLE_ENTRIES) slots and reads one lease slot
// per cycle from the lease RAM; a request that finds an existing lease stops the scan at
// that slot, while ignored and no-server requests skip the scan. A stalled result register
// holds the result back. A new request is taken only once the previous result has been
// passed to the result register.
// Reset (synchronous, active low): all lease valid flags, grant counter and config
// registers clear or load their defaults; lease RAM holds no reset.
module address_lease_table_core
    import alt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [MAC_W-1:0]   i_client_mac,
    input  logic [7:0]         i_message_type,
    input  logic [ADDR_W-1:0]  i_server_address,
    input  logic               i_server_address_valid,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [ADDR_W-1:0]  o_assigned_address,
    output logic [SIZE_W-1:0]  o_slot_index,
    output logic [SIZE_W-1:0]  o_expired_count,
    output logic [31:0]        o_grants_served
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    // scan counter must hold both pool_size and the table depth
    localparam int LIM_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int ENT_W = MAC_W + ADDR_W + LEASE_W;

    // ---------------- configuration registers ----------------
    logic [ADDR_W-1:0]  r_pool_base,     n_pool_base;
    logic [SIZE_W-1:0]  r_pool_size,     n_pool_size;
    logic [LEASE_W-1:0] r_lease_seconds, n_lease_seconds;
    logic               r_derive,        n_derive;

    // ---------------- control state ----------------
    t_state                   r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;     // one valid flag per lease slot
    logic [31:0]              r_counter, n_counter; // grants served
    logic                     r_chk_vld, n_chk_vld; // RAM read data is for a slot to check
    logic                     r_out_vld, n_out_vld;

    // ---------------- working payload ----------------
    logic [LIM_W-1:0]   r_rd_cnt,   n_rd_cnt;   // next slot to read
    logic [IDX_W-1:0]   r_chk_idx,  n_chk_idx;  // slot whose data is on the RAM output
    logic               r_have_free, n_have_free;
    logic [IDX_W-1:0]   r_hit_idx,  n_hit_idx;  // first free slot, then matched slot
    logic [ADDR_W-1:0]  r_hit_addr, n_hit_addr;
    logic [2:0]         r_status,   n_status;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic [SIZE_W-1:0]  r_expired,  n_expired;

    // latched request fields
    logic               r_op;
    logic [MAC_W-1:0]   r_mac;
    logic               r_is_discover;
    logic [23:0]        r_server_hi;

    // result register
    logic [2:0]         r_out_status,   n_out_status;
    logic [ADDR_W-1:0]  r_out_addr,     n_out_addr;
    logic [SIZE_W-1:0]  r_out_slot,     n_out_slot;
    logic [SIZE_W-1:0]  r_out_expired,  n_out_expired;
    logic [31:0]        r_out_grants,   n_out_grants;

    // ---------------- lease RAM: {client, address, remaining} ----------------
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [ENT_W-1:0]   ram_rdata;

    logic [MAC_W-1:0]   w_ent_client;
    logic [ADDR_W-1:0]  w_ent_addr;
    logic [LEASE_W-1:0] w_ent_rem;
    logic               w_slot_valid;
    logic [LIM_W-1:0]   w_limit;
    logic [LIM_W-1:0]   w_pool_ext;
    logic               w_issue;
    logic               w_in_acc;
    logic               w_out_free;
    logic [ADDR_W-1:0]  w_final_addr;

    alt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_lease_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign w_ent_client = ram_rdata[ENT_W-1 -: MAC_W];
    assign w_ent_addr   = ram_rdata[LEASE_W +: ADDR_W];
    assign w_ent_rem    = ram_rdata[LEASE_W-1:0];
    assign w_slot_valid = r_valid[r_chk_idx];

    // slots scanned: pool size, clipped to the table depth
    assign w_pool_ext = LIM_W'(r_pool_size);
    assign w_limit    = (w_pool_ext > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES)
                                                             : w_pool_ext;
    assign w_issue    = (r_rd_cnt < w_limit);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;

    // auto mode swaps in the server's subnet bytes
    assign w_final_addr = r_derive ? {r_server_hi, r_hit_addr[7:0]} : r_hit_addr;

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_counter     = r_counter;
        n_chk_vld     = 1'b0;
        n_chk_idx     = r_chk_idx;
        n_rd_cnt      = r_rd_cnt;
        n_have_free   = r_have_free;
        n_hit_idx     = r_hit_idx;
        n_hit_addr    = r_hit_addr;
        n_status      = r_status;
        n_res_addr    = r_res_addr;
        n_expired     = r_expired;
        n_out_vld     = r_out_vld && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_addr    = r_out_addr;
        n_out_slot    = r_out_slot;
        n_out_expired = r_out_expired;
        n_out_grants  = r_out_grants;
        ram_we        = 1'b0;
        ram_waddr     = r_chk_idx;
        ram_wdata     = {w_ent_client, w_ent_addr, w_ent_rem - LEASE_W'(AGE_STEP)};

        n_pool_base     = r_pool_base;
        n_pool_size     = r_pool_size;
        n_lease_seconds = r_lease_seconds;
        n_derive        = r_derive;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POOL_BASE:     n_pool_base     = i_cfg_data;
                CFG_POOL_SIZE:     n_pool_size     = i_cfg_data[SIZE_W-1:0];
                CFG_LEASE_SECONDS: n_lease_seconds = i_cfg_data[LEASE_W-1:0];
                CFG_DERIVE_SUBNET: n_derive        = i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd_cnt    = '0;
                    n_have_free = 1'b0;
                    n_expired   = '0;
                    n_res_addr  = '0;
                    // message type is checked before the server address
                    if (i_operation == OP_TICK) begin
                        n_state = S_SCAN;
                    end else if (i_message_type != MSG_DISCOVER &&
                                 i_message_type != MSG_REQUEST) begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end else if (!i_server_address_valid) begin
                        n_status = ST_NO_SERVER;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_rd_cnt  = r_rd_cnt + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_cnt[IDX_W-1:0];
                end
                if (r_chk_vld) begin
                    if (r_op == OP_TICK) begin
                        if (w_slot_valid) begin
                            if (w_ent_rem <= LEASE_W'(AGE_STEP)) begin
                                n_valid[r_chk_idx] = 1'b0;
                                n_expired          = r_expired + 1'b1;
                            end else begin
                                ram_we = 1'b1;
                            end
                        end
                    end else if (w_slot_valid && w_ent_client == r_mac) begin
                        // existing lease: stop the scan, drop the read in flight
                        n_hit_idx  = r_chk_idx;
                        n_hit_addr = w_ent_addr;
                        n_chk_vld  = 1'b0;
                        n_state    = S_GRANT;
                    end else if (!w_slot_valid && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_hit_idx   = r_chk_idx;
                    end
                end else if (!w_issue) begin
                    // every slot checked
                    if (r_op == OP_TICK) begin
                        n_status = ST_TICK;
                        n_state  = S_DONE;
                    end else if (r_have_free) begin
                        n_hit_addr = {r_pool_base[31:8], r_pool_base[7:0] + 8'(r_hit_idx)};
                        n_state    = S_GRANT;
                    end else begin
                        n_status = ST_EXHAUSTED;
                        n_state  = S_DONE;
                    end
                end
            end

            S_GRANT: begin
                ram_we             = 1'b1;
                ram_waddr          = r_hit_idx;
                ram_wdata          = {r_mac, w_final_addr, r_lease_seconds};
                n_valid[r_hit_idx] = 1'b1;
                n_counter          = r_counter + 1'b1;
                n_res_addr         = w_final_addr;
                n_status           = r_is_discover ? ST_OFFER : ST_ACK;
                n_state            = S_DONE;
            end

            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld     = 1'b1;
                    n_out_status  = r_status;
                    n_out_addr    = r_res_addr;
                    n_out_slot    = (r_status == ST_OFFER || r_status == ST_ACK)
                                    ? SIZE_W'(r_hit_idx) : '0;
                    n_out_expired = r_expired;
                    n_out_grants  = r_counter;
                    n_state       = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- state register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_counter       <= '0;
            r_chk_vld       <= 1'b0;
            r_out_vld       <= 1'b0;
            r_pool_base     <= RST_POOL_BASE;
            r_pool_size     <= RST_POOL_SIZE;
            r_lease_seconds <= RST_LEASE_SECONDS;
            r_derive        <= RST_DERIVE_SUBNET;
        end else begin
            r_valid         <= n_valid;
            r_counter       <= n_counter;
            r_chk_vld       <= n_chk_vld;
            r_out_vld       <= n_out_vld;
            r_pool_base     <= n_pool_base;
            r_pool_size     <= n_pool_size;
            r_lease_seconds <= n_lease_seconds;
            r_derive        <= n_derive;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_rd_cnt      <= n_rd_cnt;
        r_chk_idx     <= n_chk_idx;
        r_have_free   <= n_have_free;
        r_hit_idx     <= n_hit_idx;
        r_hit_addr    <= n_hit_addr;
        r_status      <= n_status;
        r_res_addr    <= n_res_addr;
        r_expired     <= n_expired;
        r_out_status  <= n_out_status;
        r_out_addr    <= n_out_addr;
        r_out_slot    <= n_out_slot;
        r_out_expired <= n_out_expired;
        r_out_grants  <= n_out_grants;
        if (w_in_acc) begin
            r_op          <= i_operation;
            r_mac         <= i_client_mac;
            r_is_discover <= (i_message_type == MSG_DISCOVER);
            r_server_hi   <= i_server_address[31:8];
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_status           = r_out_status;
    assign o_assigned_address = r_out_addr;
    assign o_slot_index       = r_out_slot;
    assign o_expired_count    = r_out_expired;
    assign o_grants_served    = r_out_grants;

    // ---------------- assertions ----------------
    a_scan_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= w_limit))
        else $error("slot scan ran past the pool");

    a_grant_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRANT) |=> r_valid[$past(r_hit_idx)])
        else $error("granted slot not marked valid");

    a_count_on_grant_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_state != S_GRANT) |=> (r_counter == $past(r_counter)))
        else $error("grant counter moved without a grant");

    a_tick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == OP_TICK) |-> (r_status == ST_TICK))
        else $error("tick finished with a request status");

    a_expired_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == OP_TICK) |-> (LIM_W'(r_expired) <= w_limit))
        else $error("tick freed more leases than the pool holds");

endmodule
